// ===== hw/rtl/qtsp_pkg.sv =====
// Shared types, codes and the zigzag map for the quantization table parser.
package qtsp_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_FIRST  = 2'd1,
    PH_LOW    = 2'd2,
    PH_SKIP   = 2'd3
  } qtsp_phase_t;

  typedef enum logic [1:0] {
    ST_WRITTEN       = 2'd0,
    ST_BAD_PRECISION = 2'd1,
    ST_TRUNCATED     = 2'd2,
    ST_BAD_ID        = 2'd3
  } qtsp_status_t;

  localparam int unsigned VALUES_PER_TABLE = 64;
  localparam logic [5:0]  LAST_VALUE       = 6'd63;

  // Work record handed from the byte classifier to the write side.
  typedef struct packed {
    logic         has_result;
    logic         do_write;
    logic         set_valid;
    logic         clr_valid;
    qtsp_status_t status;
    logic [3:0]   table_id;
    logic [5:0]   position;
    logic [15:0]  value;
    logic         table_done;
  } qtsp_rec_t;

  localparam logic [5:0] ZIGZAG [64] = '{
    6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

endpackage

// ===== hw/rtl/quant_table_segment_parser_core.sv =====
// Top level of the quantization table segment parser.
// Throughput: one payload byte per cycle, sustained, while results are taken.
// A result passes through the two-entry record queue and then the result register before
// it is presented, and waits there while results stall.
// Reset (rst, synchronous): parser expects a header, queue empties, all table
// valid marks clear; the table store itself is not cleared.
module quant_table_segment_parser_core #(
  parameter int unsigned TABLE_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        segment_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [3:0]  table_id,
  output logic [5:0]  position,
  output logic [15:0] value,
  output logic        table_done
);
  import qtsp_pkg::*;

  logic      accept;
  logic      rec_push;
  qtsp_rec_t rec;
  logic      q_pop;
  logic      q_not_empty;
  logic      q_full;
  qtsp_rec_t q_head;
  qtsp_rec_t out_rec;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  qtsp_front #(
    .TABLE_COUNT (TABLE_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .segment_end (segment_end),
    .rec_push    (rec_push),
    .rec         (rec)
  );

  qtsp_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (rec_push),
    .push_rec  (rec),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .full      (q_full),
    .head      (q_head)
  );

  qtsp_back #(
    .TABLE_COUNT (TABLE_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rec     (out_rec)
  );

  assign status     = out_rec.status;
  assign table_id   = out_rec.table_id;
  assign position   = out_rec.position;
  assign value      = out_rec.value;
  assign table_done = out_rec.table_done;

endmodule

// ===== hw/rtl/qtsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module qtsp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/qtsp_front.sv =====
// Byte classifier: tracks the segment phase and turns each byte into a work record.
module qtsp_front #(
  parameter int unsigned TABLE_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              segment_end,
  output logic              rec_push,
  output qtsp_pkg::qtsp_rec_t rec
);
  import qtsp_pkg::*;

  qtsp_phase_t phase, phase_next;
  logic [3:0]  current_table, current_table_next;
  logic        wide_values, wide_values_next;
  logic [5:0]  value_count, value_count_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;

  logic [3:0]  hdr_prec;
  logic [3:0]  hdr_id;
  logic        bad_prec;
  logic        bad_id;
  logic        last_value;
  logic [15:0] cur_value;
  logic [5:0]  cur_pos;

  assign hdr_prec   = data_byte[7:4];
  assign hdr_id     = data_byte[3:0];
  assign bad_prec   = hdr_prec > 4'd1;
  assign bad_id     = {1'b0, hdr_id} >= 5'(TABLE_COUNT);
  assign last_value = value_count == LAST_VALUE;
  assign cur_value  = (phase == PH_LOW) ? {high_byte_hold, data_byte} : {8'h00, data_byte};
  assign cur_pos    = ZIGZAG[value_count];

  // Next state
  always_comb begin
    phase_next          = phase;
    current_table_next  = current_table;
    wide_values_next    = wide_values;
    value_count_next    = value_count;
    high_byte_hold_next = high_byte_hold;
    unique case (phase)
      PH_HEADER: begin
        if (bad_prec || bad_id) begin
          phase_next = segment_end ? PH_HEADER : PH_SKIP;
        end else begin
          current_table_next = hdr_id;
          wide_values_next   = hdr_prec[0];
          value_count_next   = '0;
          phase_next         = segment_end ? PH_HEADER : PH_FIRST;
        end
      end
      PH_FIRST, PH_LOW: begin
        if (phase == PH_FIRST && wide_values) begin
          high_byte_hold_next = data_byte;
          if (segment_end) begin
            value_count_next = '0;
            phase_next       = PH_HEADER;
          end else begin
            phase_next = PH_LOW;
          end
        end else if (last_value || segment_end) begin
          value_count_next = '0;
          phase_next       = PH_HEADER;
        end else begin
          value_count_next = value_count + 6'd1;
          phase_next       = PH_FIRST;
        end
      end
      PH_SKIP: begin
        if (segment_end) begin
          phase_next = PH_HEADER;
        end
      end
      default: phase_next = PH_HEADER;
    endcase
  end

  // Record outputs
  always_comb begin
    rec          = '0;
    rec.status   = ST_WRITTEN;
    unique case (phase)
      PH_HEADER: begin
        rec.table_id = hdr_id;
        if (bad_prec) begin
          rec.has_result = 1'b1;
          rec.status     = ST_BAD_PRECISION;
        end else if (bad_id) begin
          rec.has_result = 1'b1;
          rec.status     = ST_BAD_ID;
        end else begin
          rec.clr_valid  = 1'b1;
          rec.has_result = segment_end;
          rec.status     = segment_end ? ST_TRUNCATED : ST_WRITTEN;
        end
      end
      PH_FIRST, PH_LOW: begin
        rec.table_id = current_table;
        rec.position = cur_pos;
        if (phase == PH_FIRST && wide_values) begin
          rec.has_result = segment_end;
          rec.status     = ST_TRUNCATED;
        end else begin
          rec.has_result = 1'b1;
          rec.do_write   = 1'b1;
          rec.value      = cur_value;
          rec.set_valid  = last_value;
          rec.table_done = last_value;
          rec.status     = (!last_value && segment_end) ? ST_TRUNCATED : ST_WRITTEN;
        end
      end
      PH_SKIP: begin
        rec.table_id = current_table;
      end
      default: rec.table_id = current_table;
    endcase
    rec_push = accept && (rec.has_result || rec.do_write || rec.clr_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      current_table  <= '0;
      wide_values    <= 1'b0;
      value_count    <= '0;
      high_byte_hold <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      current_table  <= current_table_next;
      wide_values    <= wide_values_next;
      value_count    <= value_count_next;
      high_byte_hold <= high_byte_hold_next;
    end
  end

  a_low_needs_wide: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LOW |-> wide_values)
    else $error("low byte phase without 16-bit precision");

endmodule

// ===== hw/rtl/qtsp_queue.sv =====
// Short FIFO of work records between the classifier and the write side.
module qtsp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  qtsp_pkg::qtsp_rec_t push_rec,
  input  logic                pop,
  output logic                not_empty,
  output logic                full,
  output qtsp_pkg::qtsp_rec_t head
);
  import qtsp_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  qtsp_rec_t      slots [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign not_empty = count != '0;
  assign full      = count == CW'(DEPTH);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/qtsp_back.sv =====
// Write side: stores values, keeps the table valid marks, drives the result register.
module qtsp_back #(
  parameter int unsigned TABLE_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_not_empty,
  input  qtsp_pkg::qtsp_rec_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output qtsp_pkg::qtsp_rec_t out_rec
);
  import qtsp_pkg::*;

  localparam int unsigned DEPTH = TABLE_COUNT * VALUES_PER_TABLE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned VW    = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;

  logic [TABLE_COUNT-1:0] table_valid;
  logic [VW-1:0]          vidx;
  logic                   we;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          chk_addr;
  logic [15:0]            rd_data;

  assign q_pop   = q_not_empty && (!out_valid || out_ready);
  assign we      = q_pop && q_head.do_write;
  assign vidx    = q_head.table_id[VW-1:0];
  assign wr_addr = AW'({q_head.table_id, q_head.position});

  qtsp_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (q_head.value),
    .rd_addr (chk_addr),
    .rd_data (rd_data)
  );

  // Read back the last written entry for the store check below.
  always_ff @(posedge clk) begin
    if (we) begin
      chk_addr <= wr_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.has_result) begin
      out_rec <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      table_valid <= '0;
    end else begin
      if (q_pop && q_head.has_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop && q_head.clr_valid) begin
        table_valid[vidx] <= 1'b0;
      end else if (q_pop && q_head.set_valid) begin
        table_valid[vidx] <= 1'b1;
      end
    end
  end

  a_done_is_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rec.table_done |-> out_rec.status == ST_WRITTEN)
    else $error("table_done on a result that is not a plain write");

  a_valid_set: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_head.set_valid |=> table_valid[$past(vidx)])
    else $error("valid mark not set after final value");

  a_valid_clr: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_head.clr_valid |=> !table_valid[$past(vidx)])
    else $error("valid mark not cleared by header");

  a_store_readback: assert property (@(posedge clk) disable iff (rst)
    $past(we, 2) && !$past(rst, 1) |-> rd_data == $past(q_head.value, 2))
    else $error("table store read back differs from written value");

endmodule

// ===== verif/quant_table_segment_parser_core_tb.sv =====
// Testbench for the quantization table segment parser: byte stream in, write records out.
module quant_table_segment_parser_core_tb;
  import qtsp_pkg::*;

  localparam int unsigned TABLE_COUNT = 4;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned BYTE_TARGET = 2000;

  typedef struct packed {
    qtsp_status_t status;
    logic [3:0]   table_id;
    logic [5:0]   position;
    logic [15:0]  value;
    logic         table_done;
  } write_record_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        segment_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [3:0]  table_id;
  logic [5:0]  position;
  logic [15:0] value;
  logic        table_done;

  // Parser model state
  qtsp_phase_t parse_state = PH_HEADER;
  logic [3:0]  load_table = '0;
  logic        load_wide = 1'b0;
  logic [5:0]  load_count = '0;
  logic [7:0]  load_high = '0;
  logic [5:0]  zigzag_pos [64];

  write_record_t pending_writes[$];
  logic [7:0]    segment_bytes[$];
  int unsigned   error_count = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   stall_cycles = 0;
  bit            tx_calm = 1'b0;
  bit            rx_calm = 1'b0;

  quant_table_segment_parser_core #(.TABLE_COUNT(TABLE_COUNT)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .segment_end(segment_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .table_id   (table_id),
    .position   (position),
    .value      (value),
    .table_done (table_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle gap: usually none, sometimes short, rarely a long stretch.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void queue_write(qtsp_status_t st, logic [3:0] id, logic [5:0] pos,
                                      logic [15:0] val, logic done);
    write_record_t rec;
    rec.status     = st;
    rec.table_id   = id;
    rec.position   = pos;
    rec.value      = val;
    rec.table_done = done;
    pending_writes.insert(pending_writes.size(), rec);
  endfunction

  // Append one byte to the segment under construction.
  function automatic void append_byte(logic [7:0] b);
    segment_bytes.insert(segment_bytes.size(), b);
  endfunction

  function automatic void store_value(logic [15:0] val, logic last);
    logic [5:0] pos;
    pos = zigzag_pos[load_count];
    if (load_count == 6'd63) begin
      load_count  = '0;
      parse_state = PH_HEADER;
      queue_write(ST_WRITTEN, load_table, pos, val, 1'b1);
    end else if (last) begin
      load_count  = '0;
      parse_state = PH_HEADER;
      queue_write(ST_TRUNCATED, load_table, pos, val, 1'b0);
    end else begin
      load_count  = load_count + 6'd1;
      parse_state = PH_FIRST;
      queue_write(ST_WRITTEN, load_table, pos, val, 1'b0);
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic last);
    logic [3:0] prec;
    logic [3:0] id;
    prec = b[7:4];
    id   = b[3:0];
    case (parse_state)
      PH_HEADER: begin
        // Precision is checked before the id.
        if (prec > 4'd1) begin
          parse_state = last ? PH_HEADER : PH_SKIP;
          queue_write(ST_BAD_PRECISION, id, '0, '0, 1'b0);
        end else if (id >= TABLE_COUNT) begin
          parse_state = last ? PH_HEADER : PH_SKIP;
          queue_write(ST_BAD_ID, id, '0, '0, 1'b0);
        end else begin
          load_table = id;
          load_wide  = prec[0];
          load_count = '0;
          if (last) begin
            parse_state = PH_HEADER;
            queue_write(ST_TRUNCATED, id, '0, '0, 1'b0);
          end else begin
            parse_state = PH_FIRST;
          end
        end
      end
      PH_FIRST: begin
        if (load_wide) begin
          load_high = b;
          if (last) begin
            queue_write(ST_TRUNCATED, load_table, zigzag_pos[load_count], '0, 1'b0);
            load_count  = '0;
            parse_state = PH_HEADER;
          end else begin
            parse_state = PH_LOW;
          end
        end else begin
          store_value({8'h00, b}, last);
        end
      end
      PH_LOW: store_value({load_high, b}, last);
      default: if (last) parse_state = PH_HEADER;
    endcase
  endfunction

  // Entered and left at a falling edge; valid stays high after the transaction.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = tx_calm ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    data_byte   = b;
    segment_end = last;
    do @(posedge clk); while (!in_ready);
    predict_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_segment();
    int i;
    for (i = 0; i < segment_bytes.size(); i++)
      send_byte(segment_bytes[i], i == segment_bytes.size() - 1);
    segment_bytes.delete();
  endtask

  task automatic add_table(input logic [3:0] id, input logic wide);
    logic [15:0] v;
    int n;
    int pick;
    append_byte({3'b000, wide, id});
    for (n = 0; n < 64; n++) begin
      pick = $urandom_range(0, 9);
      v = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
      if (wide) append_byte(v[15:8]);
      append_byte(v[7:0]);
    end
  endtask

  task automatic add_bad_header();
    if ($urandom_range(0, 1) == 0)
      append_byte({4'($urandom_range(2, 15)), 4'($urandom)});
    else
      append_byte({3'b000, 1'($urandom), 4'($urandom_range(TABLE_COUNT, 15))});
  endtask

  // Hold the sender off until every write record has come back.
  task automatic wait_for_writes();
    in_valid = 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic test_header_errors();
    send_byte(8'h2F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hF0, 1'b1);
    send_byte({4'h0, 4'(TABLE_COUNT)}, 1'b0);
    send_byte(8'h13, 1'b1);
    send_byte(8'h1F, 1'b1);
  endtask

  task automatic test_truncated_segments();
    send_byte({4'h0, 4'(TABLE_COUNT - 1)}, 1'b1);
    // 16-bit table cut between the bytes of its second value
    send_byte(8'h11, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h10, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7E, 1'b1);
  endtask

  task automatic test_multi_table_segment();
    add_table(4'd0, 1'b0);
    add_table(4'(TABLE_COUNT - 1), 1'b1);
    send_segment();
    // reload the first table in a segment of its own
    add_table(4'd0, 1'b1);
    send_segment();
    wait_for_writes();
  endtask

  task automatic test_random_segments();
    int unsigned kind;
    int unsigned n;
    int unsigned keep;
    while (bytes_sent < BYTE_TARGET) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        n = $urandom_range(1, 3);
        repeat (n) add_table(4'($urandom_range(0, TABLE_COUNT - 1)), 1'($urandom));
        if (kind >= 65) begin
          keep = $urandom_range(1, segment_bytes.size());
          while (segment_bytes.size() > keep) void'(segment_bytes.pop_back());
        end
      end else if (kind < 90) begin
        add_bad_header();
        repeat ($urandom_range(0, 6)) append_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 8)) append_byte(8'($urandom));
      end
      send_segment();
      if ($urandom_range(0, 9) == 0) wait_for_writes();
    end
  endtask

  always @(negedge clk) begin
    if (stall_cycles > 0) begin
      out_ready = 1'b0;
      stall_cycles--;
    end else begin
      out_ready = 1'b1;
      if (!rx_calm) stall_cycles = idle_gap();
    end
  end

  always @(posedge clk) begin
    write_record_t exp_rec;
    if (!rst && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected result: status %0d table_id %0d position %0d value %0h",
               status, table_id, position, value);
        error_count++;
      end else begin
        exp_rec = pending_writes.pop_front();
        if (status !== exp_rec.status) begin
          $error("status: expected %0d, got %0d", exp_rec.status, status);
          error_count++;
        end
        if (table_id !== exp_rec.table_id) begin
          $error("table_id: expected %0d, got %0d", exp_rec.table_id, table_id);
          error_count++;
        end
        if (position !== exp_rec.position) begin
          $error("position: expected %0d, got %0d", exp_rec.position, position);
          error_count++;
        end
        if (value !== exp_rec.value) begin
          $error("value: expected %0h, got %0h", exp_rec.value, value);
          error_count++;
        end
        if (table_done !== exp_rec.table_done) begin
          $error("table_done: expected %0d, got %0d", exp_rec.table_done, table_done);
          error_count++;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int s;
    int r;
    int k;
    // Walk the anti-diagonals to get the natural position of each zigzag index.
    k = 0;
    for (s = 0; s < 15; s++) begin
      if (s % 2 == 0) begin
        for (r = (s < 8 ? s : 7); r >= (s > 7 ? s - 7 : 0); r--) begin
          zigzag_pos[k] = 6'(r * 8 + (s - r));
          k++;
        end
      end else begin
        for (r = (s > 7 ? s - 7 : 0); r <= (s < 8 ? s : 7); r++) begin
          zigzag_pos[k] = 6'(r * 8 + (s - r));
          k++;
        end
      end
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_header_errors();
    test_truncated_segments();
    test_multi_table_segment();
    test_random_segments();

    in_valid = 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/qtsp_pkg.sv
hw/rtl/qtsp_ram.sv
hw/rtl/qtsp_front.sv
hw/rtl/qtsp_queue.sv
hw/rtl/qtsp_back.sv
hw/rtl/quant_table_segment_parser_core.sv
verif/quant_table_segment_parser_core_tb.sv
